// ----- sv/pip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared constants for the point-in-polygon test
// Field widths, command codes and default sizes.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 24;
    localparam int VCOUNT_BITS      = 5;
    localparam int VINDEX_BITS      = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

// ----- sv/pip_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd ray-casting point-in-polygon test
// Stores polygon vertices in a RAM and walks its edges to test a point.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers when start is high and busy is low. With cmd set to
//   write, coord_x/coord_y land in vertex slot vertex_index (slots at or
//   above MAX_VERTICES are dropped); a write gives no result. With cmd set
//   to query, the point (coord_x, coord_y) is tested against the first
//   n = min(vertex_count, MAX_VERTICES) vertices.
//   The query result appears on inside_res for exactly one cycle, marked by
//   done. The receiver cannot stall: it must take the result in that cycle.
//   A query with n > 0 holds busy until its walk ends and strobes done in the
//   first cycle with busy low; only then is a new command taken. The walk is
//   set by the single RAM read port: one vertex per cycle, the previous vertex
//   (n-1) first, then 0 .. n-1, followed by a difference stage, a multiply
//   stage and a compare stage. With n = 0 the result (outside) is strobed in
//   the cycle after the transfer. The user writes vertex_count through
//   vertex_count_we only while the block is idle; the block does not enforce
//   it. Reset clears vertex_count, the walk control and the result strobe; the
//   vertex RAM is not cleared and must be written before it is queried.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cmd,
    input  logic [pip_pkg::VINDEX_BITS-1:0] vertex_index,
    input  logic signed [COORD_BITS-1:0]    coord_x,
    input  logic signed [COORD_BITS-1:0]    coord_y,
    input  logic                            vertex_count_we,
    input  logic [pip_pkg::VCOUNT_BITS-1:0] vertex_count,
    output logic                            inside_res,
    output logic                            done
);

    import pip_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);      // RAM address width
    localparam int NW  = $clog2(MAX_VERTICES + 1);  // holds 0 .. MAX_VERTICES
    localparam int IEW = VINDEX_BITS + AW;
    localparam int CEW = VCOUNT_BITS + NW;
    localparam int DW  = COORD_BITS + 1;            // coordinate difference
    localparam int PW  = 2 * DW;                    // product

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [VCOUNT_BITS-1:0] vcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
        end
        else if (vertex_count_we)
        begin
            vcount_reg <= vertex_count;
        end
    end

    // ------------------------------------------------------------------
    // Command transfer decode
    // ------------------------------------------------------------------
    logic           accept;
    logic           wr_cmd;
    logic           qry_cmd;
    logic [IEW-1:0] idx_ext;
    logic           idx_ok;
    logic [CEW-1:0] cnt_ext;
    logic [NW-1:0]  n_sat;

    assign accept  = start && !busy;
    assign wr_cmd  = accept && (cmd == CMD_WRITE);
    assign qry_cmd = accept && (cmd == CMD_QUERY);
    assign idx_ext = IEW'(vertex_index);
    assign idx_ok  = idx_ext < IEW'(MAX_VERTICES);
    assign cnt_ext = CEW'(vcount_reg);
    // Clamp the vertex count to the store capacity.
    assign n_sat   = (cnt_ext > CEW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : cnt_ext[NW-1:0];

    // ------------------------------------------------------------------
    // Vertex RAM: {x, y} per slot
    // ------------------------------------------------------------------
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [2*COORD_BITS-1:0]   rd_data;
    logic signed [COORD_BITS-1:0] vx_rd;
    logic signed [COORD_BITS-1:0] vy_rd;

    pip_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (wr_cmd && idx_ok),
        .waddr (idx_ext[AW-1:0]),
        .wdata ({coord_x, coord_y}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign vx_rd = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign vy_rd = rd_data[COORD_BITS-1:0];

    // ------------------------------------------------------------------
    // Walk sequencer: issue n + 1 reads (vertex n-1, then 0 .. n-1)
    // ------------------------------------------------------------------
    state_t        state_reg;
    state_t        state_next;
    logic [NW-1:0] rd_cnt_reg;
    logic [NW-1:0] rd_cnt_next;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] addr_wide;
    logic          rd_last;
    logic          fin;             // final edge leaves the compare stage

    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;

    assign rd_en     = (state_reg == ST_ISSUE);
    assign addr_wide = (rd_cnt_reg == '0) ? (n_reg - NW'(1)) : (rd_cnt_reg - NW'(1));
    assign rd_addr   = addr_wide[AW-1:0];
    assign rd_last   = (rd_cnt_reg == n_reg);
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_cnt_next = '0;
                if (qry_cmd && (n_sat != '0))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                rd_cnt_next = rd_cnt_reg + NW'(1);
                if (rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // Hold the query point and clamped count for the whole walk.
    always_ff @(posedge clk)
    begin
        if (qry_cmd)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            n_reg  <= n_sat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: read data back; form differences against previous vertex
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_first_reg;
    logic s1_last_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;

    logic s2_valid_reg;
    logic s2_last_reg;
    logic s2_strad_reg;
    logic signed [DW-1:0] s2_pxd_reg;   // px - xi
    logic signed [DW-1:0] s2_dy_reg;    // yj - yi
    logic signed [DW-1:0] s2_xd_reg;    // xj - xi
    logic signed [DW-1:0] s2_pyd_reg;   // py - yi

    logic edge_v;

    assign edge_v = s1_valid_reg && !s1_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            s1_first_reg <= rd_en && (rd_cnt_reg == '0);
            s1_last_reg  <= rd_en && rd_last;
            s2_valid_reg <= edge_v;
            s2_last_reg  <= edge_v && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prev_x_reg <= vx_rd;
            prev_y_reg <= vy_rd;
        end
        if (edge_v)
        begin
            // Straddle: exactly one end strictly above the point.
            s2_strad_reg <= (vy_rd > py_reg) != (prev_y_reg > py_reg);
            s2_pxd_reg   <= DW'(px_reg) - DW'(vx_rd);
            s2_dy_reg    <= DW'(prev_y_reg) - DW'(vy_rd);
            s2_xd_reg    <= DW'(prev_x_reg) - DW'(vx_rd);
            s2_pyd_reg   <= DW'(py_reg) - DW'(vy_rd);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross products
    // ------------------------------------------------------------------
    logic s3_valid_reg;
    logic s3_last_reg;
    logic s3_strad_reg;
    logic s3_dneg_reg;
    logic signed [PW-1:0] s3_lhs_reg;
    logic signed [PW-1:0] s3_rhs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_last_reg  <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_strad_reg <= s2_strad_reg;
            s3_dneg_reg  <= s2_dy_reg[DW-1];
            s3_lhs_reg   <= PW'(s2_pxd_reg) * PW'(s2_dy_reg);
            s3_rhs_reg   <= PW'(s2_xd_reg) * PW'(s2_pyd_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compare and toggle the even-odd flag
    // ------------------------------------------------------------------
    logic left_cross;
    logic toggle;
    logic inside_reg;
    logic inside_next;
    logic done_reg;
    logic inside_res_reg;

    // The edge's y difference is never zero on a straddling edge, so its
    // sign alone picks the direction of the comparison.
    assign left_cross  = s3_dneg_reg ? (s3_lhs_reg > s3_rhs_reg) : (s3_lhs_reg < s3_rhs_reg);
    assign toggle      = s3_valid_reg && s3_strad_reg && left_cross;
    assign inside_next = inside_reg ^ toggle;
    assign fin         = s3_valid_reg && s3_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            priority if (qry_cmd)
            begin
                inside_reg <= 1'b0;
            end
            else
            begin
                inside_reg <= inside_next;
            end
            // Strobe at walk end, or straight away for an empty polygon.
            done_reg <= fin || (qry_cmd && (n_sat == '0));
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (fin)
        begin
            inside_res_reg <= inside_next;
        end
        else if (qry_cmd)
        begin
            inside_res_reg <= 1'b0;
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fin_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> done)
        else $error("walk finished without a result strobe");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while a walk is still running");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        qry_cmd |=> (busy || done))
        else $error("query transfer neither started a walk nor gave a result");

    a_drain_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !rd_en && !s1_first_reg)
        else $error("vertex read issued after the last edge read");

endmodule
